FILE: design/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// shared types and constants for the length prefix deframer
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 16;
    localparam int HDR_W  = 16;

    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 16'd2048;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [1:0] {
        PH_HEAD0   = 2'd0,
        PH_HEAD1   = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_ERROR   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } token_t;

endpackage

FILE: design/lpd_front.sv
// ----------------------------------------------------------------------------
// lpd_front
// header parser: takes stream bytes and turns each into zero or one token
// ----------------------------------------------------------------------------
module lpd_front #(
    parameter int LEN_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lpd_pkg::BYTE_W-1:0]  in_data,
    input  logic [lpd_pkg::CFG_W-1:0]   max_len,
    input  logic                        full,
    output logic                        push,
    output lpd_pkg::token_t             push_token,
    output logic                        err_flag
);
    import lpd_pkg::*;

    localparam int CMP_W = (LEN_WIDTH > CFG_W) ? LEN_WIDTH : CFG_W;

    phase_t                phase_reg, phase_next;
    logic [BYTE_W-1:0]     header_low_reg, header_low_next;
    logic [LEN_WIDTH-1:0]  bytes_left_reg, bytes_left_next;

    logic                  take;
    logic [HDR_W-1:0]      header;
    logic [LEN_WIDTH-1:0]  len;
    logic                  too_long;
    logic                  len_zero;
    logic                  final_byte;

    assign in_ready   = !full;
    assign take       = in_valid && in_ready;
    assign header     = {in_data, header_low_reg};
    assign len        = LEN_WIDTH'(header);
    assign too_long   = CMP_W'(len) > CMP_W'(max_len);
    assign len_zero   = (len == '0);
    assign final_byte = (bytes_left_reg <= LEN_WIDTH'(1));
    assign err_flag   = (phase_reg == PH_ERROR);

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        header_low_next = header_low_reg;
        bytes_left_next = bytes_left_reg;
        if (take)
        begin
            case (phase_reg)
                PH_HEAD0:
                begin
                    header_low_next = in_data;
                    phase_next      = PH_HEAD1;
                end
                PH_HEAD1:
                begin
                    if (too_long)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else if (len_zero)
                    begin
                        phase_next = PH_HEAD0;
                    end
                    else
                    begin
                        bytes_left_next = len;
                        phase_next      = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (final_byte)
                    begin
                        bytes_left_next = '0;
                        phase_next      = PH_HEAD0;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - LEN_WIDTH'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_ERROR;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        push            = 1'b0;
        push_token.kind = KIND_BYTE;
        push_token.data = '0;
        push_token.last = 1'b0;
        if (take)
        begin
            case (phase_reg)
                PH_HEAD1:
                begin
                    if (too_long)
                    begin
                        push            = 1'b1;
                        push_token.kind = KIND_ERROR;
                    end
                    else if (len_zero)
                    begin
                        push            = 1'b1;
                        push_token.kind = KIND_EMPTY;
                    end
                end
                PH_PAYLOAD:
                begin
                    push            = 1'b1;
                    push_token.data = in_data;
                    push_token.last = final_byte;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEAD0;
            header_low_reg <= '0;
            bytes_left_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            header_low_reg <= header_low_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

FILE: design/lpd_fifo.sv
// ----------------------------------------------------------------------------
// lpd_fifo
// short token queue between parser and output stage
// ----------------------------------------------------------------------------
module lpd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lpd_pkg::token_t  push_token,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output lpd_pkg::token_t  head_token
);
    import lpd_pkg::*;

    token_t                 mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head_token = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/lpd_back.sv
// ----------------------------------------------------------------------------
// lpd_back
// output stage: pulls tokens from the queue into the result register
// ----------------------------------------------------------------------------
module lpd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        not_empty,
    input  lpd_pkg::token_t             head_token,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lpd_pkg::BYTE_W-1:0]  out_data,
    output logic                        out_last,
    output logic [1:0]                  out_kind
);
    import lpd_pkg::*;

    logic    valid_reg, valid_next;
    token_t  token_reg;

    assign pop        = not_empty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = token_reg.data;
    assign out_last   = token_reg.last;
    assign out_kind   = token_reg.kind;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            token_reg <= head_token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

FILE: design/length_prefix_deframer_top.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer_top
// splits a byte stream into messages framed by a 2-byte little-endian length
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one stream byte per transaction. each message opens with a
//   2-byte length header, low byte first, then that many payload bytes.
//   m_axis gives one transaction per payload byte (tuser kind byte, tlast on
//   the final one), one kind empty transaction for a zero header, or one kind
//   error transaction for a header above max_payload_len. after an error all
//   input bytes are taken and dropped until reset.
//   cfg writes max_payload_len; it is sampled with the second header byte.
//   throughput is one byte per cycle in both directions while the queue has
//   room and m_axis does not stall. a result reaches m_axis by way of the
//   token queue, written as its byte is taken, and then the output register.
//   the four-entry token queue sets how long the input runs on while m_axis
//   is stalled; once it fills, s_axis_tready drops until m_axis drains.
//   reset clears the parser to the first header byte, empties the queue,
//   drops any pending result and restores max_payload_len to 2048.
// ----------------------------------------------------------------------------
module length_prefix_deframer_top #(
    parameter int LEN_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [lpd_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] in_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [lpd_pkg::BYTE_W-1:0]  m_axis_tdata,   // [7:0] payload_byte
    output logic                        m_axis_tlast,
    output logic [1:0]                  m_axis_tuser,   // [1:0] kind
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lpd_pkg::CFG_W-1:0]   cfg_data        // [15:0] max_payload_len
);
    import lpd_pkg::*;

    logic [CFG_W-1:0]  max_len_reg;
    logic              push;
    token_t            push_token;
    logic              full;
    logic              pop;
    logic              not_empty;
    token_t            head_token;
    logic              err_flag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_len_reg <= cfg_data;
        end
    end

    lpd_front #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .max_len    (max_len_reg),
        .full       (full),
        .push       (push),
        .push_token (push_token),
        .err_flag   (err_flag)
    );

    lpd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .full       (full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head_token (head_token)
    );

    lpd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .not_empty  (not_empty),
        .head_token (head_token),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_kind   (m_axis_tuser)
    );

    // error phase is sticky until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(err_flag) |-> err_flag)
        else $error("error phase left without reset");

    // an error result is only shown once the parser sits in the error phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_ERROR)) |-> err_flag)
        else $error("error result without error phase");

    // only payload bytes carry tlast
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != KIND_BYTE)) |-> !m_axis_tlast)
        else $error("tlast on a non-payload result");

    // nothing is queued while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("token pushed into a full queue");

endmodule
